[rtl/core/prewitt_pkg.sv]
package prewitt_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int DIM_BITS   = 13;
  localparam int THR_BITS   = 11;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int WIN        = 3;
  localparam int SUM_BITS   = PIXEL_BITS + 3;
  localparam int MAG_BITS   = PIXEL_BITS + 3;

  localparam logic [DIM_BITS-1:0]   MIN_DIM       = DIM_BITS'(3);
  localparam logic [DIM_BITS-1:0]   MAX_DIM_W     = DIM_BITS'(MAX_WIDTH);
  localparam logic [DIM_BITS-1:0]   MAX_DIM_H     = DIM_BITS'(MAX_HEIGHT);
  localparam logic [DIM_BITS-1:0]   WIDTH_RESET   = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET  = DIM_BITS'(480);
  localparam logic [THR_BITS-1:0]   THRESH_RESET  = THR_BITS'(128);
  localparam logic [PIXEL_BITS-1:0] EDGE_ON       = '1;
  localparam logic [PIXEL_BITS-1:0] EDGE_OFF      = '0;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

endpackage

[rtl/core/prewitt_edge_threshold_3x3_top.sv]
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------
// pixel    | pixel_valid / pixel_stall | pixel_value
// edge     | edge_valid / edge_stall   | edge_value, frame_last
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One pixel per cycle unless pixel_stall holds it; a result passes the read stage, then the output register.
// Line store read sets the first stage, the gradient sum and
// threshold compare fill the second, which loads the output register.
// rst is synchronous; it resets counters, window, valid flags, cfg regs; not the line stores.
// A stall on edge holds the output register, then the read stage, then pixel.
module prewitt_edge_threshold_3x3_top
  import prewitt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [PIXEL_BITS-1:0] pixel_value,
  output logic                  edge_valid,
  input  logic                  edge_stall,
  output logic [PIXEL_BITS-1:0] edge_value,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [DIM_BITS-1:0]   cfg_data
);

  logic [DIM_BITS-1:0]  row_length;
  logic [DIM_BITS-1:0]  frame_rows;
  logic [THR_BITS-1:0]  edge_threshold;

  pixel_t               line_upper [MAX_WIDTH];
  pixel_t               line_lower [MAX_WIDTH];
  pixel_t               rd_top;
  pixel_t               rd_mid;

  pixel_t               window [WIN][WIN];
  pixel_t               window_next [WIN][WIN];

  logic [ADDR_BITS-1:0] column_count;
  logic [ROW_BITS-1:0]  row_count;
  logic [DIM_BITS-1:0]  width_eff;
  logic [DIM_BITS-1:0]  height_eff;
  logic [DIM_BITS-1:0]  col_plus;
  logic [DIM_BITS-1:0]  row_plus;
  logic                 row_end;
  logic                 frame_end;
  logic                 accept;

  logic                 s1_valid;
  logic                 s1_produce;
  logic                 s1_frame_end;
  logic [ADDR_BITS-1:0] s1_col;
  pixel_t               s1_pix;
  logic                 s1_adv;
  logic                 out_free;

  logic signed [SUM_BITS-1:0] gx;
  logic signed [SUM_BITS-1:0] gy;
  logic [SUM_BITS-1:0]        gx_abs;
  logic [SUM_BITS-1:0]        gy_abs;
  logic [MAG_BITS-1:0]        mag;

  function automatic logic signed [SUM_BITS-1:0] sx(input pixel_t v);
    return signed'({3'b000, v});
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= WIDTH_RESET;
      frame_rows     <= HEIGHT_RESET;
      edge_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:     row_length     <= cfg_data;
        REG_HEIGHT:    frame_rows     <= cfg_data;
        REG_THRESHOLD: edge_threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = row_length;
    if (row_length < MIN_DIM) width_eff = MIN_DIM;
    else if (row_length > MAX_DIM_W) width_eff = MAX_DIM_W;
    height_eff = frame_rows;
    if (frame_rows < MIN_DIM) height_eff = MIN_DIM;
    else if (frame_rows > MAX_DIM_H) height_eff = MAX_DIM_H;
  end

  assign col_plus  = DIM_BITS'(column_count) + DIM_BITS'(1);
  assign row_plus  = DIM_BITS'(row_count) + DIM_BITS'(1);
  assign row_end   = col_plus >= width_eff;
  assign frame_end = row_end && (row_plus >= height_eff);

  assign out_free    = !edge_valid || !edge_stall;
  assign s1_adv      = s1_valid && (!s1_produce || out_free);
  assign pixel_stall = s1_valid && !s1_adv;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_plus[ROW_BITS-1:0];
      end else begin
        column_count <= col_plus[ADDR_BITS-1:0];
      end
    end
  end

  // Read at acceptance, write back when the item leaves the read stage.
  always_ff @(posedge clk) begin
    if (s1_adv) line_upper[s1_col] <= rd_mid;
    if (accept) rd_top <= line_upper[column_count];
  end

  always_ff @(posedge clk) begin
    if (s1_adv) line_lower[s1_col] <= s1_pix;
    if (accept) rd_mid <= line_lower[column_count];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col       <= column_count;
      s1_pix       <= pixel_value;
      s1_produce   <= (row_count >= ROW_BITS'(2)) && (column_count >= ADDR_BITS'(2));
      s1_frame_end <= frame_end;
    end
  end

  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      window_next[r][0] = window[r][1];
      window_next[r][1] = window[r][2];
    end
    window_next[0][2] = rd_top;
    window_next[1][2] = rd_mid;
    window_next[2][2] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          window[r][c] <= '0;
        end
      end
    end else if (s1_adv) begin
      window <= window_next;
    end
  end

  always_comb begin
    gx = '0;
    gy = '0;
    for (int r = 0; r < WIN; r++) begin
      gx = gx + sx(window_next[r][2]) - sx(window_next[r][0]);
      gy = gy + sx(window_next[2][r]) - sx(window_next[0][r]);
    end
    gx_abs = gx[SUM_BITS-1] ? SUM_BITS'(-gx) : SUM_BITS'(gx);
    gy_abs = gy[SUM_BITS-1] ? SUM_BITS'(-gy) : SUM_BITS'(gy);
    mag    = MAG_BITS'(gx_abs + gy_abs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_valid <= 1'b0;
    end else if (s1_adv && s1_produce) begin
      edge_valid <= 1'b1;
    end else if (!edge_stall) begin
      edge_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_produce) begin
      edge_value <= (mag > MAG_BITS'(edge_threshold)) ? EDGE_ON : EDGE_OFF;
      frame_last <= s1_frame_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not enter the read stage");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (s1_valid && s1_produce && edge_valid && edge_stall))
    else $error("pixel stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_produce) |=> edge_valid)
    else $error("interior pixel lost its result");

  a_edge_levels: assert property (@(posedge clk) disable iff (rst)
    edge_valid |-> (edge_value == EDGE_ON || edge_value == EDGE_OFF))
    else $error("edge value neither on nor off");
`endif

endmodule
